### rtl/per_pkg.sv
// shared types, codes and constants for the page residency evictor
// used by every module of the block except per_ram; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package per_pkg;

    // page map geometry
    localparam int MAX_PAGES = 4096;
    localparam int PAGE_W    = $clog2(MAX_PAGES);
    localparam int SLOT_W    = PAGE_W + 1;
    localparam int WIN_W     = PAGE_W + 2;
    localparam int EPOCH_W   = 8;
    localparam int MEM_W     = EPOCH_W + 1;

    // the victim search gives up after this many probes
    localparam logic [SLOT_W-1:0] WALK_LIMIT = SLOT_W'(MAX_PAGES + 2);

    // register clamps and reset values
    localparam logic [4:0]        SHIFT_MIN   = 5'd4;
    localparam logic [4:0]        SHIFT_MAX   = 5'd16;
    localparam logic [4:0]        SHIFT_RESET = 5'd12;
    localparam logic [12:0]       CAP_RESET   = 13'd8;
    localparam logic [SLOT_W-1:0] CAP_MAX     = SLOT_W'(MAX_PAGES);

    // register indexes on the configuration port
    localparam logic [1:0] REG_PAGE_SIZE_LOG2     = 2'd0;
    localparam logic [1:0] REG_MAX_RESIDENT_PAGES = 2'd1;
    localparam logic [1:0] REG_DATA_LENGTH        = 2'd2;

    // operation codes
    localparam logic [1:0] OP_OPEN   = 2'd0;
    localparam logic [1:0] OP_ACCESS = 2'd1;
    localparam logic [1:0] OP_CLOSE  = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_OK           = 3'd0;
    localparam logic [2:0] STAT_RESIDENT     = 3'd1;
    localparam logic [2:0] STAT_LOADED       = 3'd2;
    localparam logic [2:0] STAT_NOT_OPEN     = 3'd3;
    localparam logic [2:0] STAT_OUT_OF_RANGE = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_LOAD,
        ST_RESP
    } state_t;

    // clamped configuration as the datapath sees it
    typedef struct packed {
        logic [4:0]        shift;
        logic [SLOT_W-1:0] cap;
        logic [31:0]       data_length;
    } cfg_t;

    // decoded byte offset
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [15:0]       poff;
        logic              out_of_range;
    } dec_t;

    // write and read requests to the residency memory
    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] waddr;
        logic [MEM_W-1:0]  wdata;
        logic              re;
        logic [PAGE_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [PAGE_W-1:0] page_index;
        logic [15:0]       page_offset;
        logic              fetch_request;
        logic              evicted;
        logic [PAGE_W-1:0] evicted_page;
    } result_t;

endpackage

`default_nettype wire

### rtl/per_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module per_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/per_cfg.sv
// configuration register file behind the apb port, with range clamping
// depends on per_pkg
`timescale 1ns / 1ps
`default_nettype none

module per_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    output per_pkg::cfg_t     cfg
);

    import per_pkg::*;

    logic [4:0]  page_size_log2_reg;
    logic [12:0] max_resident_pages_reg;
    logic [31:0] data_length_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_log2_reg     <= SHIFT_RESET;
            max_resident_pages_reg <= CAP_RESET;
            data_length_reg        <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_PAGE_SIZE_LOG2:     page_size_log2_reg     <= pwdata[4:0];
                REG_MAX_RESIDENT_PAGES: max_resident_pages_reg <= pwdata[12:0];
                REG_DATA_LENGTH:        data_length_reg        <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (paddr[3:2])
            REG_PAGE_SIZE_LOG2:     prdata = {27'd0, page_size_log2_reg};
            REG_MAX_RESIDENT_PAGES: prdata = {19'd0, max_resident_pages_reg};
            REG_DATA_LENGTH:        prdata = data_length_reg;
            default:                prdata = '0;
        endcase
    end

    // clamp to the legal ranges
    always_comb
    begin
        if (page_size_log2_reg < SHIFT_MIN)
        begin
            cfg.shift = SHIFT_MIN;
        end
        else if (page_size_log2_reg > SHIFT_MAX)
        begin
            cfg.shift = SHIFT_MAX;
        end
        else
        begin
            cfg.shift = page_size_log2_reg;
        end

        if (max_resident_pages_reg == '0)
        begin
            cfg.cap = SLOT_W'(1);
        end
        else if (SLOT_W'(max_resident_pages_reg) > CAP_MAX)
        begin
            cfg.cap = CAP_MAX;
        end
        else
        begin
            cfg.cap = SLOT_W'(max_resident_pages_reg);
        end

        cfg.data_length = data_length_reg;
    end

endmodule

`default_nettype wire

### rtl/per_decode.sv
// splits a byte offset into page index and in-page position, flags range errors
// depends on per_pkg
`timescale 1ns / 1ps
`default_nettype none

module per_decode (
    input  wire logic [31:0] offset,
    input  wire per_pkg::cfg_t cfg,
    output per_pkg::dec_t    dec
);

    import per_pkg::*;

    logic [31:0] page_full;
    logic [31:0] mask;
    logic [31:0] masked;

    always_comb
    begin
        page_full = offset >> cfg.shift;
        mask      = (32'd1 << cfg.shift) - 32'd1;
        masked    = offset & mask;

        dec.page         = page_full[PAGE_W-1:0];
        dec.poff         = masked[15:0];
        dec.out_of_range = (offset >= cfg.data_length) || (|page_full[31:PAGE_W]);
    end

endmodule

`default_nettype wire

### rtl/per_ctrl.sv
// sequencer: residency lookup, victim walk, page load, clearing pass, result register
// depends on per_pkg; drives the residency memory through a mem_req_t bundle
`timescale 1ns / 1ps
`default_nettype none

module per_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire per_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    in_op,
    input  wire per_pkg::dec_t                 in_dec,
    output per_pkg::mem_req_t                  mem_req,
    input  wire logic [per_pkg::MEM_W-1:0]     mem_rdata,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output per_pkg::result_t                   out_result
);

    import per_pkg::*;

    state_t                   state_reg, state_next;
    logic [1:0]               op_reg, op_next;
    dec_t                     dec_reg, dec_next;
    logic                     is_open_reg, is_open_next;
    logic [EPOCH_W-1:0]       epoch_reg, epoch_next;
    logic [SLOT_W-1:0]        free_reg, free_next;
    logic signed [WIN_W-1:0]  low_reg, low_next;
    logic signed [WIN_W-1:0]  high_reg, high_next;
    logic [PAGE_W-1:0]        cur_reg, cur_next;
    logic                     dir_up_reg, dir_up_next;
    logic [SLOT_W-1:0]        walk_cnt_reg, walk_cnt_next;
    logic signed [WIN_W-1:0]  probe_reg, probe_next;
    logic                     probe_valid_reg, probe_valid_next;
    logic                     ev_reg, ev_next;
    logic [PAGE_W-1:0]        evp_reg, evp_next;
    logic [PAGE_W-1:0]        clr_addr_reg, clr_addr_next;
    logic                     resp_pend_reg, resp_pend_next;
    result_t                  res_reg, res_next;
    result_t                  out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    logic                     entry_hit;
    logic                     out_free;
    logic                     finish;
    logic                     wrap;
    result_t                  res_c;
    logic signed [WIN_W:0]    dl, dh;
    logic [WIN_W:0]           adl, adh;
    logic signed [WIN_W-1:0]  page_s;
    logic signed [WIN_W-1:0]  walk_idx;
    logic                     probe_in_map;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // entry belongs to the current epoch and is marked resident
    assign entry_hit = mem_rdata[EPOCH_W] && (mem_rdata[EPOCH_W-1:0] == epoch_reg);
    assign out_free  = !out_valid_reg || out_ready;

    // window distances for the eviction direction
    always_comb
    begin
        page_s = signed'({2'b00, dec_reg.page});
        dl     = {low_reg[WIN_W-1], low_reg} - {page_s[WIN_W-1], page_s};
        dh     = {high_reg[WIN_W-1], high_reg} - {page_s[WIN_W-1], page_s};
        adl    = dl[WIN_W] ? unsigned'(-dl) : unsigned'(dl);
        adh    = dh[WIN_W] ? unsigned'(-dh) : unsigned'(dh);
        walk_idx     = dir_up_reg ? low_reg : high_reg;
        probe_in_map = !probe_reg[WIN_W-1] && !probe_reg[WIN_W-2];
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            is_open_reg     <= 1'b0;
            epoch_reg       <= '0;
            free_reg        <= SLOT_W'(CAP_RESET);
            low_reg         <= '1;
            high_reg        <= '1;
            cur_reg         <= '0;
            clr_addr_reg    <= '0;
            resp_pend_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            probe_valid_reg <= 1'b0;
            walk_cnt_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            is_open_reg     <= is_open_next;
            epoch_reg       <= epoch_next;
            free_reg        <= free_next;
            low_reg         <= low_next;
            high_reg        <= high_next;
            cur_reg         <= cur_next;
            clr_addr_reg    <= clr_addr_next;
            resp_pend_reg   <= resp_pend_next;
            out_valid_reg   <= out_valid_next;
            probe_valid_reg <= probe_valid_next;
            walk_cnt_reg    <= walk_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        dec_reg    <= dec_next;
        dir_up_reg <= dir_up_next;
        probe_reg  <= probe_next;
        ev_reg     <= ev_next;
        evp_reg    <= evp_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        dec_next         = dec_reg;
        is_open_next     = is_open_reg;
        epoch_next       = epoch_reg;
        free_next        = free_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        cur_next         = cur_reg;
        dir_up_next      = dir_up_reg;
        walk_cnt_next    = walk_cnt_reg;
        probe_next       = probe_reg;
        probe_valid_next = probe_valid_reg;
        ev_next          = ev_reg;
        evp_next         = evp_reg;
        clr_addr_next    = clr_addr_reg;
        resp_pend_next   = resp_pend_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        mem_req          = '0;
        res_c            = '0;
        finish           = 1'b0;
        wrap             = 1'b0;

        case (state_reg)
            // sweep the whole map back to not resident, but keep page 0 resident while open
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_addr_reg;
                if ((clr_addr_reg == '0) && is_open_reg)
                begin
                    mem_req.wdata = {1'b1, EPOCH_W'(0)};
                end
                clr_addr_next = clr_addr_reg + PAGE_W'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next     = resp_pend_reg ? ST_RESP : ST_IDLE;
                    resp_pend_next = 1'b0;
                end
            end

            // take a transaction and start the residency read
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = in_op;
                    dec_next      = in_dec;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = in_dec.page;
                    state_next    = ST_CHECK;
                end
            end

            // decide on the looked-up entry
            ST_CHECK:
            begin
                case (op_reg)
                    OP_OPEN:
                    begin
                        finish        = 1'b1;
                        wrap          = (epoch_reg == '1);
                        epoch_next    = epoch_reg + EPOCH_W'(1);
                        low_next      = '0;
                        high_next     = '0;
                        free_next     = cfg.cap - SLOT_W'(1);
                        cur_next      = '0;
                        is_open_next  = 1'b1;
                        mem_req.we    = 1'b1;
                        mem_req.waddr = '0;
                        mem_req.wdata = {1'b1, epoch_reg + EPOCH_W'(1)};
                        res_c.status        = STAT_LOADED;
                        res_c.fetch_request = 1'b1;
                    end
                    OP_ACCESS:
                    begin
                        if (!is_open_reg)
                        begin
                            finish       = 1'b1;
                            res_c.status = STAT_NOT_OPEN;
                        end
                        else if (dec_reg.out_of_range)
                        begin
                            finish       = 1'b1;
                            res_c.status = STAT_OUT_OF_RANGE;
                        end
                        else if (dec_reg.page == cur_reg)
                        begin
                            finish            = 1'b1;
                            res_c.status      = STAT_OK;
                            res_c.page_index  = cur_reg;
                            res_c.page_offset = dec_reg.poff;
                        end
                        else if (entry_hit)
                        begin
                            finish            = 1'b1;
                            cur_next          = dec_reg.page;
                            res_c.status      = STAT_RESIDENT;
                            res_c.page_index  = dec_reg.page;
                            res_c.page_offset = dec_reg.poff;
                        end
                        else
                        begin
                            ev_next  = 1'b0;
                            evp_next = '0;
                            if (free_reg != '0)
                            begin
                                state_next = ST_LOAD;
                            end
                            else
                            begin
                                // evict from the window end farther from the page
                                dir_up_next      = (adl > adh);
                                walk_cnt_next    = '0;
                                probe_valid_next = 1'b0;
                                state_next       = ST_WALK;
                            end
                        end
                    end
                    OP_CLOSE:
                    begin
                        finish = 1'b1;
                        if (!is_open_reg)
                        begin
                            res_c.status = STAT_NOT_OPEN;
                        end
                        else
                        begin
                            wrap         = (epoch_reg == '1);
                            epoch_next   = epoch_reg + EPOCH_W'(1);
                            low_next     = '1;
                            high_next    = '1;
                            free_next    = cfg.cap;
                            is_open_next = 1'b0;
                            res_c.status = STAT_OK;
                        end
                    end
                    default:
                    begin
                        finish       = 1'b1;
                        res_c.status = STAT_OK;
                    end
                endcase
            end

            // probe one map entry per cycle, check the previous probe
            ST_WALK:
            begin
                if (probe_valid_reg && probe_in_map && entry_hit)
                begin
                    mem_req.we       = 1'b1;
                    mem_req.waddr    = probe_reg[PAGE_W-1:0];
                    mem_req.wdata    = '0;
                    ev_next          = 1'b1;
                    evp_next         = probe_reg[PAGE_W-1:0];
                    probe_valid_next = 1'b0;
                    if (dir_up_reg)
                    begin
                        low_next = probe_reg + WIN_W'(1);
                    end
                    else
                    begin
                        high_next = probe_reg - WIN_W'(1);
                    end
                    state_next = ST_LOAD;
                end
                else if (walk_cnt_reg == WALK_LIMIT)
                begin
                    probe_valid_next = 1'b0;
                    state_next       = ST_LOAD;
                end
                else
                begin
                    mem_req.re       = 1'b1;
                    mem_req.raddr    = walk_idx[PAGE_W-1:0];
                    probe_next       = walk_idx;
                    probe_valid_next = 1'b1;
                    walk_cnt_next    = walk_cnt_reg + SLOT_W'(1);
                    if (dir_up_reg)
                    begin
                        low_next = low_reg + WIN_W'(1);
                    end
                    else
                    begin
                        high_next = high_reg - WIN_W'(1);
                    end
                end
            end

            // mark the wanted page resident and widen the window
            ST_LOAD:
            begin
                finish        = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.waddr = dec_reg.page;
                mem_req.wdata = {1'b1, epoch_reg};
                if (free_reg != '0)
                begin
                    free_next = free_reg - SLOT_W'(1);
                end
                if (page_s < low_reg)
                begin
                    low_next = page_s;
                end
                if (page_s > high_reg)
                begin
                    high_next = page_s;
                end
                cur_next            = dec_reg.page;
                res_c.status        = STAT_LOADED;
                res_c.page_index    = dec_reg.page;
                res_c.page_offset   = dec_reg.poff;
                res_c.fetch_request = 1'b1;
                res_c.evicted       = ev_reg;
                res_c.evicted_page  = evp_reg;
            end

            // result waits for the output register
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // hand a finished result to the output register or park it
        if (finish)
        begin
            if (wrap)
            begin
                res_next       = res_c;
                resp_pend_next = 1'b1;
                clr_addr_next  = '0;
                state_next     = ST_CLEAR;
            end
            else if (out_free)
            begin
                out_next       = res_c;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            else
            begin
                res_next   = res_c;
                state_next = ST_RESP;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/page_residency_evictor_core.sv
// Page residency evictor, top level.
//
// Input stream (s_axis_*): one transaction per operation; tuser carries the
// operation (open, byte access, close), tdata the byte offset. Output stream
// (m_axis_*): exactly one result transaction per input transaction, in order;
// tuser carries the status, tdata the page index, in-page offset, fetch
// request, eviction flag and evicted page.
// Configuration (apb): page size, buffer capacity and data length, to be
// written by the user only while the block is idle; the block does not
// enforce this. pready is always high. Open, close, hits and errors are
// decided in the check state; a miss with a free slot goes on to the load
// state; a miss that must evict first walks the residency map one page per
// cycle from a window end, then loads. One transaction is in progress at
// a time; s_axis_tready is high only between transactions.
// Residency lives in a 4096 x 9 bit memory tagged with an epoch count so that
// open and close clear it at once. After reset, and on every 256th open or
// close, a clearing pass sweeps all 4096 entries of the memory with s_axis_tready
// low. A result stalled by m_axis_tready waits in the output register; the
// next transaction is taken while it waits, and its result is held back.
// Depends on per_pkg, per_cfg, per_decode, per_ctrl and per_ram.
`timescale 1ns / 1ps
`default_nettype none

module page_residency_evictor_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] offset
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] op
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [47:0] m_axis_tdata,   // [11:0] page_index, [27:12] page_offset,
                                             // [28] fetch_request, [29] evicted,
                                             // [41:30] evicted_page, [47:42] zero
    output logic      [2:0]  m_axis_tuser,   // [2:0] status
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    import per_pkg::*;

    cfg_t               cfg;
    dec_t               dec;
    mem_req_t           mem_req;
    logic [MEM_W-1:0]   mem_rdata;
    result_t            result;

    // configuration registers
    per_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // offset to page decode
    per_decode u_decode (
        .offset (s_axis_tdata),
        .cfg    (cfg),
        .dec    (dec)
    );

    // sequencer
    per_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (s_axis_tuser),
        .in_dec     (dec),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // residency map with epoch tags
    per_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_PAGES)
    ) u_map (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    // result packing
    assign m_axis_tuser = result.status;
    assign m_axis_tdata = {6'd0, result.evicted_page, result.evicted, result.fetch_request,
                           result.page_offset, result.page_index};

endmodule

`default_nettype wire

### rtl/per_checker.sv
// port-level checks for the page residency evictor, bound to the top level
// depends on per_pkg and page_residency_evictor_core
`timescale 1ns / 1ps
`default_nettype none

module per_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [47:0] m_axis_tdata,
    input  wire logic [2:0]  m_axis_tuser
);

    import per_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // one transaction at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("back to back accept");

    // a fetch is only requested on a load
    a_fetch_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[28] |-> m_axis_tuser == STAT_LOADED)
        else $error("fetch request without load status");

    // an eviction only comes with a fetch
    a_evict_with_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[29] |-> m_axis_tdata[28])
        else $error("eviction without fetch");

    // error results carry nothing else
    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == STAT_NOT_OPEN || m_axis_tuser == STAT_OUT_OF_RANGE)
        |-> m_axis_tdata == '0)
        else $error("error result with payload");

endmodule

bind page_residency_evictor_core per_checker u_per_checker (.*);

`default_nettype wire
